@@ rtl/core/cea_pkg.sv @@
// ----------------------------------------------------------------------------
// cea_pkg
// Shared types and codes for the 6502 effective-address sequencer.
// ----------------------------------------------------------------------------
package cea_pkg;

    localparam logic       ACT_START = 1'b0;
    localparam logic       ACT_BYTE  = 1'b1;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] MODE_IMP  = 4'd0;
    localparam logic [3:0] MODE_ACC  = 4'd1;
    localparam logic [3:0] MODE_IMM  = 4'd2;
    localparam logic [3:0] MODE_ZP   = 4'd3;
    localparam logic [3:0] MODE_ZPX  = 4'd4;
    localparam logic [3:0] MODE_ZPY  = 4'd5;
    localparam logic [3:0] MODE_ABS  = 4'd6;
    localparam logic [3:0] MODE_ABSX = 4'd7;
    localparam logic [3:0] MODE_ABSY = 4'd8;
    localparam logic [3:0] MODE_IND  = 4'd9;
    localparam logic [3:0] MODE_INDX = 4'd10;
    localparam logic [3:0] MODE_INDY = 4'd11;
    localparam logic [3:0] MODE_REL  = 4'd12;

    typedef struct packed {
        logic        action;
        logic [3:0]  mode;
        logic [15:0] pc_in;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_data;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] read_address;
        logic [15:0] effective_address;
        logic [15:0] pc_out;
        logic [15:0] branch_offset;
        logic        page_crossed;
    } out_word_t;

    typedef struct packed {
        logic        busy;
        logic [3:0]  mode_held;
        logic [15:0] pc_held;
        logic [7:0]  x_held;
        logic [7:0]  y_held;
        logic [2:0]  phase;
        logic [7:0]  operand_lo;
        logic [15:0] pointer_word;
    } seq_state_t;

endpackage

@@ rtl/core/cpu_effective_address_sequencer.sv @@
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the result register drains as it loads.
// Input stalls only while a result waits and the output side stalls.
// Reset: sequencer returns to idle with cleared state, result register empty.
// ----------------------------------------------------------------------------
// cpu_effective_address_sequencer
// 6502 operand address sequencer: issues operand and pointer reads and
// reports the effective address, advanced PC, branch offset and page flag.
// ----------------------------------------------------------------------------
module cpu_effective_address_sequencer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cea_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cea_pkg::out_word_t rsp_word
);

    cea_pkg::seq_state_t state_reg;
    cea_pkg::seq_state_t state_next;
    cea_pkg::seq_state_t step_state;
    cea_pkg::out_word_t  step_result;
    logic                accept;

    assign req_stall = rsp_valid & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    cea_step u_step
    (
        .state      (state_reg),
        .word       (req_word),
        .state_next (step_state),
        .result     (step_result)
    );

    always_comb
    begin
        state_next = state_reg;
        if (accept) begin
            state_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else begin
            state_reg <= state_next;
        end
    end

    cea_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_word (step_result),
        .stall     (rsp_stall),
        .valid     (rsp_valid),
        .word      (rsp_word)
    );

endmodule

@@ rtl/core/cea_step.sv @@
// ----------------------------------------------------------------------------
// cea_step
// Next-state and result logic for one accepted word of the sequencer.
// ----------------------------------------------------------------------------
module cea_step
(
    input  cea_pkg::seq_state_t state,
    input  cea_pkg::in_word_t   word,
    output cea_pkg::seq_state_t state_next,
    output cea_pkg::out_word_t  result
);

    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [15:0] base;
    logic [15:0] ea_idx;
    logic [7:0]  idx;
    logic [7:0]  b;

    assign b      = word.read_data;
    assign pc1    = state.pc_held + 16'd1;
    assign pc2    = state.pc_held + 16'd2;
    assign base   = {b, state.operand_lo};
    assign idx    = (state.mode_held == cea_pkg::MODE_ABSX) ? state.x_held : state.y_held;
    assign ea_idx = base + {8'h00, idx};

    always_comb
    begin
        state_next = state;
        result     = '0;
        if (word.action == cea_pkg::ACT_START)
        begin
            if (state.busy || word.mode > cea_pkg::MODE_REL)
            begin
                result.kind = cea_pkg::KIND_ERR;
            end
            else
            begin
                state_next.mode_held    = word.mode;
                state_next.pc_held      = word.pc_in;
                state_next.x_held       = word.index_x;
                state_next.y_held       = word.index_y;
                state_next.phase        = 3'd0;
                state_next.operand_lo   = 8'h00;
                state_next.pointer_word = 16'h0000;
                if (word.mode == cea_pkg::MODE_IMP || word.mode == cea_pkg::MODE_ACC)
                begin
                    result.kind   = cea_pkg::KIND_DONE;
                    result.pc_out = word.pc_in;
                end
                else if (word.mode == cea_pkg::MODE_IMM)
                begin
                    result.kind              = cea_pkg::KIND_DONE;
                    result.effective_address = word.pc_in;
                    result.pc_out            = word.pc_in + 16'd1;
                end
                else
                begin
                    state_next.busy     = 1'b1;
                    result.kind         = cea_pkg::KIND_READ;
                    result.read_address = word.pc_in;
                end
            end
        end
        else if (!state.busy)
        begin
            result.kind = cea_pkg::KIND_ERR;
        end
        else
        begin
            // assume finish; request arms override
            state_next.busy  = 1'b0;
            state_next.phase = 3'd0;
            result.kind      = cea_pkg::KIND_DONE;
            case (state.mode_held)
                cea_pkg::MODE_ZP:
                begin
                    result.effective_address = {8'h00, b};
                    result.pc_out            = pc1;
                end
                cea_pkg::MODE_ZPX:
                begin
                    result.effective_address = {8'h00, b + state.x_held};
                    result.pc_out            = pc1;
                end
                cea_pkg::MODE_ZPY:
                begin
                    result.effective_address = {8'h00, b + state.y_held};
                    result.pc_out            = pc1;
                end
                cea_pkg::MODE_ABS, cea_pkg::MODE_ABSX, cea_pkg::MODE_ABSY:
                begin
                    if (state.phase == 3'd0)
                    begin
                        state_next.busy       = 1'b1;
                        state_next.phase      = state.phase + 3'd1;
                        state_next.operand_lo = b;
                        result.kind           = cea_pkg::KIND_READ;
                        result.read_address   = pc1;
                    end
                    else if (state.mode_held == cea_pkg::MODE_ABS)
                    begin
                        result.effective_address = base;
                        result.pc_out            = pc2;
                    end
                    else
                    begin
                        result.effective_address = ea_idx;
                        result.pc_out            = pc2;
                        result.page_crossed      = (ea_idx[15:8] != base[15:8]);
                    end
                end
                cea_pkg::MODE_IND:
                begin
                    if (state.phase == 3'd0)
                    begin
                        state_next.busy       = 1'b1;
                        state_next.phase      = state.phase + 3'd1;
                        state_next.operand_lo = b;
                        result.kind           = cea_pkg::KIND_READ;
                        result.read_address   = pc1;
                    end
                    else if (state.phase == 3'd1)
                    begin
                        state_next.busy         = 1'b1;
                        state_next.phase        = state.phase + 3'd1;
                        state_next.pointer_word = base;
                        result.kind             = cea_pkg::KIND_READ;
                        result.read_address     = base;
                    end
                    else if (state.phase == 3'd2)
                    begin
                        // keep the page-wrap quirk on the high pointer byte
                        state_next.busy       = 1'b1;
                        state_next.phase      = state.phase + 3'd1;
                        state_next.operand_lo = b;
                        result.kind           = cea_pkg::KIND_READ;
                        result.read_address   = {state.pointer_word[15:8],
                                                 state.pointer_word[7:0] + 8'd1};
                    end
                    else
                    begin
                        result.effective_address = base;
                        result.pc_out            = pc2;
                    end
                end
                cea_pkg::MODE_INDX, cea_pkg::MODE_INDY:
                begin
                    if (state.phase == 3'd0)
                    begin
                        state_next.busy         = 1'b1;
                        state_next.phase        = state.phase + 3'd1;
                        state_next.pointer_word = {8'h00, b +
                            ((state.mode_held == cea_pkg::MODE_INDX) ? state.x_held : 8'h00)};
                        result.kind             = cea_pkg::KIND_READ;
                        result.read_address     = state_next.pointer_word;
                    end
                    else if (state.phase == 3'd1)
                    begin
                        state_next.busy       = 1'b1;
                        state_next.phase      = state.phase + 3'd1;
                        state_next.operand_lo = b;
                        result.kind           = cea_pkg::KIND_READ;
                        result.read_address   = {8'h00, state.pointer_word[7:0] + 8'd1};
                    end
                    else if (state.mode_held == cea_pkg::MODE_INDX)
                    begin
                        result.effective_address = base;
                        result.pc_out            = pc1;
                    end
                    else
                    begin
                        result.effective_address = ea_idx;
                        result.pc_out            = pc1;
                        result.page_crossed      = (ea_idx[15:8] != base[15:8]);
                    end
                end
                cea_pkg::MODE_REL:
                begin
                    result.pc_out        = pc1;
                    result.branch_offset = {{8{b[7]}}, b};
                end
                default:
                begin
                    result.kind = cea_pkg::KIND_ERR;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/cea_out_reg.sv @@
// ----------------------------------------------------------------------------
// cea_out_reg
// Result register holding one word until the receiver takes it.
// ----------------------------------------------------------------------------
module cea_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cea_pkg::out_word_t load_word,
    input  logic               stall,
    output logic               valid,
    output cea_pkg::out_word_t word
);

    logic               valid_reg;
    logic               valid_next;
    cea_pkg::out_word_t word_reg;
    cea_pkg::out_word_t word_next;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (load) begin
            valid_next = 1'b1;
            word_next  = load_word;
        end
        else if (!stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

@@ tb/cpu_effective_address_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// cpu_effective_address_sequencer_tb
// Self-checking bench for the 6502 operand address sequencer. A short table
// covers every addressing mode, the wrap cases and the rejected words. Random
// instruction sequences follow, with broken ones and stray words mixed in.
// A shadow copy of the sequencer predicts each result word that the table does not give. Both sides idle
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module cpu_effective_address_sequencer_tb;

    localparam logic [3:0] MODE_BAD_LO = cea_pkg::MODE_REL + 4'd1;
    localparam logic [3:0] MODE_BAD_HI = 4'hF;
    localparam int RANDOM_WORDS = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        cea_pkg::in_word_t  stim;
        bit                 typed;
        cea_pkg::out_word_t want;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    cea_pkg::in_word_t  req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    cea_pkg::out_word_t rsp_word;

    cea_pkg::seq_state_t shadow = '0;
    cea_pkg::out_word_t  sequencer_results[$];
    plan_row_t           table_rows[$];
    cea_pkg::out_word_t  want;

    int  good_items = 0;
    int  words_sent = 0;
    int  errors = 0;
    int  n_read = 0;
    int  n_done = 0;
    int  n_err = 0;
    int  n_page = 0;
    int  cycles = 0;
    bit  calm_stretch = 1'b0;
    bit  drain_hold = 1'b0;

    cpu_effective_address_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic cea_pkg::out_word_t advance_sequencer(input cea_pkg::in_word_t w);
        cea_pkg::out_word_t r;
        logic [15:0]        pc1;
        logic [15:0]        pc2;
        logic [15:0]        base;
        logic [7:0]         zp;
        logic [7:0]         idx;
        r = '0;
        pc1 = shadow.pc_held + 16'd1;
        pc2 = shadow.pc_held + 16'd2;
        if (w.action == cea_pkg::ACT_START)
        begin
            if (shadow.busy || w.mode > cea_pkg::MODE_REL)
            begin
                r.kind = cea_pkg::KIND_ERR;
                return r;
            end
            shadow = '0;
            shadow.mode_held = w.mode;
            shadow.pc_held = w.pc_in;
            shadow.x_held = w.index_x;
            shadow.y_held = w.index_y;
            if (w.mode == cea_pkg::MODE_IMP || w.mode == cea_pkg::MODE_ACC)
            begin
                r.kind = cea_pkg::KIND_DONE;
                r.pc_out = w.pc_in;
            end
            else if (w.mode == cea_pkg::MODE_IMM)
            begin
                r.kind = cea_pkg::KIND_DONE;
                r.effective_address = w.pc_in;
                r.pc_out = w.pc_in + 16'd1;
            end
            else
            begin
                shadow.busy = 1'b1;
                r.kind = cea_pkg::KIND_READ;
                r.read_address = w.pc_in;
            end
            return r;
        end
        if (!shadow.busy)
        begin
            r.kind = cea_pkg::KIND_ERR;
            return r;
        end
        r.kind = cea_pkg::KIND_READ;
        case (shadow.mode_held)
            cea_pkg::MODE_ZP, cea_pkg::MODE_ZPX, cea_pkg::MODE_ZPY:
            begin
                idx = (shadow.mode_held == cea_pkg::MODE_ZPX) ? shadow.x_held :
                      (shadow.mode_held == cea_pkg::MODE_ZPY) ? shadow.y_held : 8'h00;
                zp = w.read_data + idx;
                r.kind = cea_pkg::KIND_DONE;
                r.effective_address = {8'h00, zp};
                r.pc_out = pc1;
            end
            cea_pkg::MODE_ABS, cea_pkg::MODE_ABSX, cea_pkg::MODE_ABSY:
            begin
                if (shadow.phase == 3'd0)
                begin
                    shadow.operand_lo = w.read_data;
                    r.read_address = pc1;
                end
                else
                begin
                    base = {w.read_data, shadow.operand_lo};
                    idx = (shadow.mode_held == cea_pkg::MODE_ABSX) ? shadow.x_held :
                          (shadow.mode_held == cea_pkg::MODE_ABSY) ? shadow.y_held : 8'h00;
                    r.kind = cea_pkg::KIND_DONE;
                    r.effective_address = base + {8'h00, idx};
                    r.pc_out = pc2;
                    r.page_crossed = (r.effective_address[15:8] != base[15:8]);
                end
            end
            cea_pkg::MODE_IND:
            begin
                case (shadow.phase)
                    3'd0:
                    begin
                        shadow.operand_lo = w.read_data;
                        r.read_address = pc1;
                    end
                    3'd1:
                    begin
                        shadow.pointer_word = {w.read_data, shadow.operand_lo};
                        r.read_address = shadow.pointer_word;
                    end
                    3'd2:
                    begin
                        shadow.operand_lo = w.read_data;
                        r.read_address = {shadow.pointer_word[15:8],
                                          shadow.pointer_word[7:0] + 8'd1};
                    end
                    default:
                    begin
                        r.kind = cea_pkg::KIND_DONE;
                        r.effective_address = {w.read_data, shadow.operand_lo};
                        r.pc_out = pc2;
                    end
                endcase
            end
            cea_pkg::MODE_INDX, cea_pkg::MODE_INDY:
            begin
                if (shadow.phase == 3'd0)
                begin
                    idx = (shadow.mode_held == cea_pkg::MODE_INDX) ? shadow.x_held : 8'h00;
                    zp = w.read_data + idx;
                    shadow.pointer_word = {8'h00, zp};
                    r.read_address = shadow.pointer_word;
                end
                else if (shadow.phase == 3'd1)
                begin
                    shadow.operand_lo = w.read_data;
                    r.read_address = {8'h00, shadow.pointer_word[7:0] + 8'd1};
                end
                else
                begin
                    base = {w.read_data, shadow.operand_lo};
                    idx = (shadow.mode_held == cea_pkg::MODE_INDY) ? shadow.y_held : 8'h00;
                    r.kind = cea_pkg::KIND_DONE;
                    r.effective_address = base + {8'h00, idx};
                    r.pc_out = pc1;
                    r.page_crossed = (r.effective_address[15:8] != base[15:8]);
                end
            end
            cea_pkg::MODE_REL:
            begin
                r.kind = cea_pkg::KIND_DONE;
                r.branch_offset = {{8{w.read_data[7]}}, w.read_data};
                r.pc_out = pc1;
            end
            default:
            begin
                r.kind = cea_pkg::KIND_ERR;
            end
        endcase
        if (r.kind == cea_pkg::KIND_READ)
        begin
            shadow.phase = shadow.phase + 3'd1;
        end
        else
        begin
            shadow.busy = 1'b0;
            shadow.phase = 3'd0;
        end
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cea_pkg::in_word_t random_word(input logic act);
        cea_pkg::in_word_t w;
        w.action = act;
        w.mode = 4'($urandom);
        w.pc_in = 16'($urandom);
        w.index_x = 8'($urandom);
        w.index_y = 8'($urandom);
        w.read_data = 8'($urandom);
        return w;
    endfunction

    function automatic cea_pkg::in_word_t start_word(input logic [3:0] m,
                                                     input logic [15:0] pc,
                                                     input logic [7:0] x,
                                                     input logic [7:0] y);
        cea_pkg::in_word_t w;
        w = '0;
        w.action = cea_pkg::ACT_START;
        w.mode = m;
        w.pc_in = pc;
        w.index_x = x;
        w.index_y = y;
        return w;
    endfunction

    function automatic cea_pkg::in_word_t byte_word(input logic [7:0] d);
        cea_pkg::in_word_t w;
        w = '0;
        w.action = cea_pkg::ACT_BYTE;
        w.read_data = d;
        return w;
    endfunction

    function automatic cea_pkg::out_word_t reply(input logic [1:0] k, input logic [15:0] ra,
                                                 input logic [15:0] ea, input logic [15:0] po,
                                                 input logic pg);
        cea_pkg::out_word_t r;
        r = '0;
        r.kind = k;
        r.read_address = ra;
        r.effective_address = ea;
        r.pc_out = po;
        r.page_crossed = pg;
        return r;
    endfunction

    task automatic add_row(input cea_pkg::in_word_t s, input bit t,
                           input cea_pkg::out_word_t r);
        plan_row_t row;
        row.stim = s;
        row.typed = t;
        row.want = r;
        table_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input cea_pkg::in_word_t w, input bit typed,
                             input cea_pkg::out_word_t typed_want);
        int                 gap;
        cea_pkg::out_word_t model;
        gap = calm_stretch ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        forever
        begin
            @(posedge clk);
            if (req_valid && !req_stall)
                break;
        end
        model = advance_sequencer(w);
        sequencer_results.push_back(typed ? typed_want : model);
        words_sent++;
        if (model.kind != cea_pkg::KIND_ERR)
            good_items++;
        calm_stretch = (good_items >= 400 && good_items < 500);
        @(negedge clk);
    endtask

    task automatic send_random(input logic act);
        send_word(random_word(act), 1'b0, '0);
    endtask

    initial
    begin
        int run;
        run = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (drain_hold)
            begin
                rsp_stall <= 1'b1;
            end
            else if (run > 0)
            begin
                rsp_stall <= 1'b1;
                run--;
            end
            else
            begin
                run = calm_stretch ? 0 : idle_len();
                rsp_stall <= 1'b0;
            end
        end
    end

    // hold the result side off while the sender keeps offering words
    initial
    begin
        while (good_items < 700)
            @(posedge clk);
        drain_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        drain_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (sequencer_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: kind %0d ra %h ea %h pc %h off %h pg %b",
                             rsp_word.kind, rsp_word.read_address,
                             rsp_word.effective_address, rsp_word.pc_out,
                             rsp_word.branch_offset, rsp_word.page_crossed);
            end
            else
            begin
                want = sequencer_results.pop_front();
                if (rsp_word.kind !== want.kind
                    || rsp_word.read_address !== want.read_address
                    || rsp_word.effective_address !== want.effective_address
                    || rsp_word.pc_out !== want.pc_out
                    || rsp_word.branch_offset !== want.branch_offset
                    || rsp_word.page_crossed !== want.page_crossed)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: got kind %0d ra %h ea %h pc %h off %h pg %b,",
                                  " want kind %0d ra %h ea %h pc %h off %h pg %b"},
                                 rsp_word.kind, rsp_word.read_address,
                                 rsp_word.effective_address, rsp_word.pc_out,
                                 rsp_word.branch_offset, rsp_word.page_crossed,
                                 want.kind, want.read_address, want.effective_address,
                                 want.pc_out, want.branch_offset, want.page_crossed);
                end
                case (want.kind)
                    cea_pkg::KIND_READ: n_read++;
                    cea_pkg::KIND_DONE: n_done++;
                    default:            n_err++;
                endcase
                if (want.page_crossed)
                    n_page++;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("cpu_effective_address_sequencer regression: fail");
        $finish;
    end

    initial
    begin
        cea_pkg::in_word_t w;
        int                pick;
        int                settle;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;

        add_row(byte_word(8'hFF), 1'b1,
                reply(cea_pkg::KIND_ERR, 16'h0, 16'h0, 16'h0, 1'b0));
        add_row(start_word(MODE_BAD_LO, 16'h1000, 8'h00, 8'h00), 1'b1,
                reply(cea_pkg::KIND_ERR, 16'h0, 16'h0, 16'h0, 1'b0));
        add_row(start_word(cea_pkg::MODE_IMP, 16'hFFFF, 8'hFF, 8'hFF), 1'b1,
                reply(cea_pkg::KIND_DONE, 16'h0, 16'h0, 16'hFFFF, 1'b0));
        add_row(start_word(cea_pkg::MODE_ACC, 16'h0000, 8'h00, 8'h00), 1'b1,
                reply(cea_pkg::KIND_DONE, 16'h0, 16'h0, 16'h0000, 1'b0));
        add_row(start_word(cea_pkg::MODE_IMM, 16'hFFFF, 8'h00, 8'h00), 1'b1,
                reply(cea_pkg::KIND_DONE, 16'h0, 16'hFFFF, 16'h0000, 1'b0));
        add_row(start_word(cea_pkg::MODE_ZP, 16'h1234, 8'h00, 8'h00), 1'b0, '0);
        add_row(byte_word(8'hFF), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_ZPX, 16'h0000, 8'hFF, 8'h00), 1'b0, '0);
        add_row(byte_word(8'hFF), 1'b1,
                reply(cea_pkg::KIND_DONE, 16'h0, 16'h00FE, 16'h0001, 1'b0));
        add_row(start_word(cea_pkg::MODE_ZPY, 16'h2000, 8'h00, 8'h80), 1'b0, '0);
        add_row(byte_word(8'h90), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_ABS, 16'h8000, 8'h11, 8'h22), 1'b0, '0);
        add_row(byte_word(8'h34), 1'b0, '0);
        add_row(byte_word(8'h12), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_ABSX, 16'hFFFF, 8'hFF, 8'h00), 1'b1,
                reply(cea_pkg::KIND_READ, 16'hFFFF, 16'h0, 16'h0, 1'b0));
        add_row(start_word(cea_pkg::MODE_IMP, 16'h0000, 8'h00, 8'h00), 1'b1,
                reply(cea_pkg::KIND_ERR, 16'h0, 16'h0, 16'h0, 1'b0));
        add_row(byte_word(8'hFF), 1'b1,
                reply(cea_pkg::KIND_READ, 16'h0000, 16'h0, 16'h0, 1'b0));
        add_row(byte_word(8'hFF), 1'b1,
                reply(cea_pkg::KIND_DONE, 16'h0, 16'h00FE, 16'h0001, 1'b1));
        add_row(start_word(cea_pkg::MODE_ABSY, 16'h4000, 8'hFF, 8'h00), 1'b0, '0);
        add_row(byte_word(8'h00), 1'b0, '0);
        add_row(byte_word(8'h80), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_IND, 16'h0300, 8'h00, 8'h00), 1'b0, '0);
        add_row(byte_word(8'hFF), 1'b0, '0);
        add_row(byte_word(8'h10), 1'b0, '0);
        add_row(byte_word(8'h34), 1'b0, '0);
        add_row(byte_word(8'h12), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_INDX, 16'h6000, 8'hFF, 8'h00), 1'b0, '0);
        add_row(byte_word(8'h01), 1'b0, '0);
        add_row(byte_word(8'h78), 1'b0, '0);
        add_row(byte_word(8'h56), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_INDY, 16'h5000, 8'h00, 8'hFF), 1'b0, '0);
        add_row(byte_word(8'hFF), 1'b0, '0);
        add_row(byte_word(8'h80), 1'b0, '0);
        add_row(byte_word(8'h12), 1'b0, '0);
        add_row(start_word(cea_pkg::MODE_REL, 16'hFFFE, 8'h00, 8'h00), 1'b0, '0);
        add_row(byte_word(8'h80), 1'b0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
            send_word(table_rows[i].stim, table_rows[i].typed, table_rows[i].want);

        good_items = 0;
        while (good_items < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                while (shadow.busy)
                    send_random(cea_pkg::ACT_BYTE);
                w = random_word(cea_pkg::ACT_START);
                w.mode = 4'($urandom_range(cea_pkg::MODE_IMP, cea_pkg::MODE_REL));
                if ($urandom_range(0, 9) == 0)
                    w.pc_in = 16'hFFFF - 16'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    w.index_x = 8'hFF;
                if ($urandom_range(0, 3) == 0)
                    w.index_y = 8'hFF;
                send_word(w, 1'b0, '0);
                while (shadow.busy)
                begin
                    if ($urandom_range(0, 49) == 0)
                        send_random(cea_pkg::ACT_START);
                    else
                        send_random(cea_pkg::ACT_BYTE);
                end
            end
            else if (pick < 92)
            begin
                w = random_word(cea_pkg::ACT_START);
                w.mode = 4'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
                send_word(w, 1'b0, '0);
            end
            else if (pick < 97)
            begin
                send_random(cea_pkg::ACT_BYTE);
            end
            else
            begin
                // start a sequence and send one byte; modes that take more bytes are left busy
                w = random_word(cea_pkg::ACT_START);
                w.mode = 4'($urandom_range(cea_pkg::MODE_ZP, cea_pkg::MODE_REL));
                send_word(w, 1'b0, '0);
                send_random(cea_pkg::ACT_BYTE);
            end
        end
        req_valid <= 1'b0;

        settle = 0;
        while (sequencer_results.size() != 0 && settle < DRAIN_LIMIT)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (4) @(posedge clk);
        if (sequencer_results.size() != 0)
        begin
            errors += sequencer_results.size();
            $display("%0d result words never arrived", sequencer_results.size());
        end

        $display("sent %0d words: %0d read requests, %0d addresses done, %0d rejected",
                 words_sent, n_read, n_done, n_err);
        $display("%0d page crossings seen, %0d mismatches", n_page, errors);
        if (errors == 0)
            $display("cpu_effective_address_sequencer regression: pass");
        else
            $display("cpu_effective_address_sequencer regression: fail");
        $finish;
    end

endmodule
